>>> rtl/core/bemfzc_pkg.sv
// Package for the back-EMF zero-crossing detector: sizes, types, register codes
// and reset values shared by the interfaces, the sequencer and the top level.
// No dependencies.
package bemfzc_pkg;

  localparam int HistDepth   = 32;
  localparam int AddrW       = $clog2(HistDepth);
  localparam int SizeW       = $clog2(HistDepth + 1);
  localparam int TickMult    = 1;
  localparam int TimeBits    = 32;
  localparam int SampleW     = 12;
  localparam int SumW        = 32;
  localparam int WordW       = 36;
  localparam int EntryW      = 3 * SampleW;
  localparam int MinAcceptUs = 300;
  localparam int QShift      = 15;
  localparam int FilterShift = 3;
  localparam int ResizeDiv   = 32;
  localparam int NeedDiv     = ResizeDiv * TickMult;

  localparam logic [15:0] HystReset   = 16'd64;
  localparam logic [11:0] MinLvlReset = 12'd100;
  localparam logic [15:0] GuardReset  = 16'd50;
  localparam logic [15:0] MaxPerReset = 16'd10000;
  localparam logic [15:0] AdvReset    = 16'd0;
  localparam logic [15:0] DetDlyReset = 16'd16;

  typedef logic [AddrW-1:0]          addr_t;
  typedef logic [SizeW-1:0]          size_t;
  typedef logic [EntryW-1:0]         entry_t;
  typedef logic [SampleW-1:0]        sample_t;
  typedef logic [TimeBits-1:0]       time_t;
  typedef logic signed [WordW-1:0]   word_t;

  typedef enum logic [2:0] {
    CFG_HYST    = 3'd0,
    CFG_MIN_LVL = 3'd1,
    CFG_GUARD   = 3'd2,
    CFG_MAX_PER = 3'd3,
    CFG_ADVANCE = 3'd4,
    CFG_DET_DLY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] hysteresis;
    logic [11:0] min_level;
    logic [15:0] guard_time_us;
    logic [15:0] max_period_us;
    logic [15:0] advance_us;
    logic [15:0] detect_delay_us;
  } cfg_t;

  typedef struct packed {
    logic    operation;
    time_t   now_us;
    sample_t phase_a;
    sample_t phase_b;
    sample_t phase_c;
  } item_t;

  typedef struct packed {
    logic        alarm_valid;
    logic [15:0] alarm_delay_us;
    logic [15:0] crossing_period_us;
    logic [2:0]  phase_flags;
    size_t       window_length;
    logic        rejected_crossing;
  } result_t;

  function automatic word_t zx(input logic [SumW-1:0] v);
    return word_t'({{(WordW - SumW){1'b0}}, v});
  endfunction

endpackage

>>> rtl/core/bemfzc_if.sv
// Valid/ready channel interfaces for the zero-crossing detector: sample input
// and result output. Depends on bemfzc_pkg.
interface bemfzc_in_if;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  bemfzc_pkg::time_t      now_us;
  bemfzc_pkg::sample_t    phase_a;
  bemfzc_pkg::sample_t    phase_b;
  bemfzc_pkg::sample_t    phase_c;

  modport source (output valid, operation, now_us, phase_a, phase_b, phase_c, input ready);
  modport sink (input valid, operation, now_us, phase_a, phase_b, phase_c, output ready);
endinterface

interface bemfzc_out_if;
  logic                valid;
  logic                ready;
  logic                alarm_valid;
  logic [15:0]         alarm_delay_us;
  logic [15:0]         crossing_period_us;
  logic [2:0]          phase_flags;
  bemfzc_pkg::size_t   window_length;
  logic                rejected_crossing;

  modport source (output valid, alarm_valid, alarm_delay_us, crossing_period_us,
                  phase_flags, window_length, rejected_crossing, input ready);
  modport sink (input valid, alarm_valid, alarm_delay_us, crossing_period_us,
                phase_flags, window_length, rejected_crossing, output ready);
endinterface

>>> rtl/core/bemfzc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bemfzc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/bemfzc_alu.sv
// Shared three-operand adder of the detector: a + b - c on signed words.
// Depends on bemfzc_pkg.
module bemfzc_alu (
  input  bemfzc_pkg::word_t a_i,
  input  bemfzc_pkg::word_t b_i,
  input  bemfzc_pkg::word_t c_i,
  output bemfzc_pkg::word_t res_o
);
  import bemfzc_pkg::*;

  assign res_o = a_i + b_i - c_i;

endmodule

>>> rtl/core/bemfzc_ctrl.sv
// Sequencer of the zero-crossing detector: window store, running sums,
// hysteresis tests, period filter and window resize, all through the shared
// adder and the window RAM. Depends on bemfzc_pkg.
module bemfzc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bemfzc_pkg::item_t   item_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output bemfzc_pkg::result_t result_o,
  input  bemfzc_pkg::cfg_t    cfg_i,
  input  logic                reseed_i,
  output bemfzc_pkg::word_t   alu_a_o,
  output bemfzc_pkg::word_t   alu_b_o,
  output bemfzc_pkg::word_t   alu_c_o,
  input  bemfzc_pkg::word_t   alu_res_i,
  output logic                ram_we_o,
  output bemfzc_pkg::addr_t   ram_waddr_o,
  output bemfzc_pkg::entry_t  ram_wdata_o,
  output bemfzc_pkg::addr_t   ram_raddr_o,
  input  bemfzc_pkg::entry_t  ram_rdata_i
);
  import bemfzc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BLANK, ST_WR, ST_CAP, ST_SUM, ST_TOT1, ST_TOT2, ST_ELAP,
    ST_DWIN, ST_MEAN, ST_BIAS, ST_CMP, ST_DIFF, ST_FILT, ST_DL1, ST_DL2,
    ST_DW, ST_RESIZE, ST_GRD, ST_SHR, ST_SHW, ST_KR, ST_KW, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_SAMPLE, M_GROW, M_SHRINK
  } mode_e;

  state_e      state_q;
  mode_e       mode_q;
  logic [1:0]  ph_q;
  time_t       now_q;
  sample_t     smp_q [3];
  sample_t     old_q [3];
  logic [SumW-1:0] sum_q [3];
  addr_t       wp_q;
  size_t       ws_q;
  size_t       i_q;
  logic [2:0]  flags_q;
  logic        blank_q;
  time_t       comm_q;
  time_t       ct_q;
  time_t       el_q;
  logic [31:0] q_q;
  logic [15:0] pi_q;
  logic [15:0] dw_q;
  word_t       t_q;
  word_t       t2_q;
  logic [19:0] thr_q;
  logic        valid_q [HistDepth];
  logic        rd_vld_q;
  logic        alarm_q;
  logic        rej_q;
  logic [15:0] delay_q;
  logic        out_valid_q;
  result_t     res_q;

  entry_t      rd_data;
  addr_t       wp_next;
  addr_t       shr_wp;
  size_t       ws_dec;
  logic [15:0] per_clamp;
  logic [15:0] need;
  logic [13:0] lvl3;
  word_t       own, oth1, oth2;
  logic        res_load;

  assign rd_data   = rd_vld_q ? ram_rdata_i : '0;
  assign wp_next   = ((size_t'(wp_q) + size_t'(1)) == ws_q) ? '0 : addr_t'(wp_q + addr_t'(1));
  assign ws_dec    = ws_q - size_t'(1);
  assign shr_wp    = (size_t'(wp_q) >= ws_dec) ? '0 : wp_q;
  assign per_clamp = (el_q > time_t'(cfg_i.max_period_us)) ? cfg_i.max_period_us : el_q[15:0];
  assign need      = 16'(pi_q / NeedDiv);
  assign lvl3      = 14'(3 * 32'(cfg_i.min_level) + 1);
  assign own       = zx(sum_q[ph_q]);
  assign oth1      = (ph_q == 2'd0) ? zx(sum_q[1]) : zx(sum_q[0]);
  assign oth2      = (ph_q == 2'd2) ? zx(sum_q[1]) : zx(sum_q[2]);
  assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    alu_a_o     = '0;
    alu_b_o     = '0;
    alu_c_o     = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = {smp_q[0], smp_q[1], smp_q[2]};
    ram_raddr_o = wp_q;
    unique case (state_q)
      ST_BLANK: begin
        alu_a_o = zx(32'(now_q));
        alu_c_o = zx(32'(comm_q));
      end
      ST_WR: begin
        ram_we_o    = 1'b1;
        ram_raddr_o = wp_next;
      end
      ST_SUM: begin
        alu_a_o = zx(sum_q[ph_q]);
        unique case (mode_q)
          M_SAMPLE: begin
            alu_b_o = zx(32'(smp_q[ph_q]));
            alu_c_o = zx(32'(old_q[ph_q]));
          end
          M_GROW:   alu_b_o = zx(32'(old_q[ph_q]));
          default:  alu_c_o = zx(32'(old_q[ph_q]));
        endcase
      end
      ST_TOT1: begin
        alu_a_o = zx(sum_q[0]);
        alu_b_o = zx(sum_q[1]);
      end
      ST_TOT2: begin
        alu_a_o = t_q;
        alu_b_o = zx(sum_q[2]);
        alu_c_o = zx(32'(thr_q));
      end
      ST_ELAP: begin
        alu_a_o = zx(32'(now_q));
        alu_c_o = zx(32'(ct_q));
      end
      ST_DWIN: begin
        alu_a_o = zx(32'(dw_q));
        alu_c_o = zx(32'(el_q));
      end
      ST_MEAN: begin
        alu_a_o = oth1;
        alu_b_o = oth2;
      end
      ST_BIAS: begin
        // rising test biases the mean, falling test biases the own sum
        alu_a_o = flags_q[ph_q] ? own : t_q;
        alu_b_o = zx(32'(cfg_i.hysteresis));
      end
      ST_CMP: begin
        alu_a_o = flags_q[ph_q] ? t_q : own;
        alu_c_o = t2_q;
      end
      ST_DIFF: begin
        alu_a_o = zx(32'(per_clamp) << QShift);
        alu_c_o = zx(q_q);
      end
      ST_FILT: begin
        alu_a_o = zx(q_q);
        alu_b_o = t_q >>> FilterShift;
      end
      ST_DL1: begin
        alu_a_o = zx(32'(pi_q >> 1));
        alu_c_o = zx(32'(cfg_i.detect_delay_us) * (HistDepth / 2));
      end
      ST_DL2: begin
        alu_a_o = t_q;
        alu_c_o = zx(32'(cfg_i.advance_us));
      end
      ST_DW: begin
        alu_a_o = zx(32'(pi_q));
        alu_b_o = zx(32'(pi_q) << 1);
      end
      ST_SHR: ram_raddr_o = addr_t'(i_q - size_t'(1));
      ST_SHW: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_t'(i_q);
        ram_wdata_o = rd_data;
      end
      ST_KR: begin
        ram_raddr_o = ((i_q + size_t'(1)) < ws_q) ? addr_t'(i_q + size_t'(1)) : shr_wp;
      end
      ST_KW: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_t'(i_q);
        ram_wdata_o = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= M_SAMPLE;
      ph_q        <= '0;
      now_q       <= '0;
      smp_q       <= '{default: '0};
      old_q       <= '{default: '0};
      sum_q       <= '{default: '0};
      wp_q        <= '0;
      ws_q        <= size_t'(HistDepth);
      i_q         <= '0;
      flags_q     <= '0;
      blank_q     <= 1'b0;
      comm_q      <= '0;
      ct_q        <= '0;
      el_q        <= '0;
      q_q         <= 32'(MaxPerReset >> 1) << QShift;
      pi_q        <= MaxPerReset >> 1;
      dw_q        <= MaxPerReset;
      t_q         <= '0;
      t2_q        <= '0;
      thr_q       <= '0;
      valid_q     <= '{default: 1'b0};
      rd_vld_q    <= 1'b0;
      alarm_q     <= 1'b0;
      rej_q       <= 1'b0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      rd_vld_q <= valid_q[ram_raddr_o];
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (reseed_i) begin
        q_q  <= 32'(cfg_i.max_period_us >> 1) << QShift;
        pi_q <= cfg_i.max_period_us >> 1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            now_q    <= item_i.now_us;
            smp_q[0] <= item_i.phase_a;
            smp_q[1] <= item_i.phase_b;
            smp_q[2] <= item_i.phase_c;
            alarm_q  <= 1'b0;
            rej_q    <= 1'b0;
            delay_q  <= '0;
            if (item_i.operation) begin
              blank_q <= 1'b1;
              comm_q  <= item_i.now_us;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_BLANK;
            end
          end
        end
        ST_BLANK: begin
          if (!blank_q) begin
            state_q <= ST_WR;
          end else if (alu_res_i[TimeBits-1:0] > time_t'(cfg_i.guard_time_us)) begin
            blank_q <= 1'b0;
            state_q <= ST_WR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_WR: begin
          valid_q[wp_q] <= 1'b1;
          wp_q          <= wp_next;
          mode_q        <= M_SAMPLE;
          state_q       <= ST_CAP;
        end
        ST_CAP: begin
          old_q[0] <= rd_data[3*SampleW-1:2*SampleW];
          old_q[1] <= rd_data[2*SampleW-1:SampleW];
          old_q[2] <= rd_data[SampleW-1:0];
          thr_q    <= 20'(lvl3) * 20'(ws_q);
          ph_q     <= '0;
          state_q  <= ST_SUM;
        end
        ST_SUM: begin
          sum_q[ph_q] <= alu_res_i[SumW-1:0];
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            unique case (mode_q)
              M_SAMPLE: state_q <= ST_TOT1;
              M_GROW: begin
                i_q     <= ws_q;
                state_q <= ST_SHR;
              end
              default: state_q <= ST_DONE;
            endcase
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        ST_TOT1: begin
          t_q     <= alu_res_i;
          state_q <= ST_TOT2;
        end
        ST_TOT2: begin
          // mean level test: total >= (3 * min_level + 1) * window
          state_q <= alu_res_i[WordW-1] ? ST_DONE : ST_ELAP;
        end
        ST_ELAP: begin
          el_q    <= alu_res_i[TimeBits-1:0];
          state_q <= ST_DWIN;
        end
        ST_DWIN: begin
          ph_q    <= '0;
          state_q <= alu_res_i[WordW-1] ? ST_MEAN : ST_DONE;
        end
        ST_MEAN: begin
          t_q     <= alu_res_i >>> 1;
          state_q <= ST_BIAS;
        end
        ST_BIAS: begin
          t2_q    <= alu_res_i;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!alu_res_i[WordW-1]) begin
            flags_q[ph_q] <= ~flags_q[ph_q];
            if (el_q > time_t'(MinAcceptUs)) begin
              state_q <= ST_DIFF;
            end else begin
              ct_q    <= now_q;
              rej_q   <= 1'b1;
              state_q <= ST_DONE;
            end
          end else if (ph_q == 2'd2) begin
            state_q <= ST_DONE;
          end else begin
            ph_q    <= ph_q + 2'd1;
            state_q <= ST_MEAN;
          end
        end
        ST_DIFF: begin
          t_q     <= alu_res_i;
          state_q <= ST_FILT;
        end
        ST_FILT: begin
          q_q     <= alu_res_i[31:0];
          pi_q    <= alu_res_i[QShift+15:QShift];
          state_q <= ST_DL1;
        end
        ST_DL1: begin
          t_q     <= alu_res_i;
          state_q <= ST_DL2;
        end
        ST_DL2: begin
          priority if (alu_res_i[WordW-1]) begin
            delay_q <= '0;
          end else if (alu_res_i > word_t'(16'hFFFF)) begin
            delay_q <= 16'hFFFF;
          end else begin
            delay_q <= alu_res_i[15:0];
          end
          alarm_q <= 1'b1;
          state_q <= ST_DW;
        end
        ST_DW: begin
          dw_q    <= alu_res_i[17:2];
          blank_q <= 1'b0;
          ct_q    <= now_q;
          state_q <= ST_RESIZE;
        end
        ST_RESIZE: begin
          priority if ((17'(need) > 17'(ws_q) + 17'd1) && (ws_q < size_t'(HistDepth))) begin
            mode_q  <= M_GROW;
            state_q <= ST_GRD;
          end else if ((17'(need) + 17'd1 < 17'(ws_q)) && (need > 16'd1)) begin
            i_q     <= size_t'(wp_q);
            state_q <= ST_KR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_GRD: state_q <= ST_CAP;
        ST_SHR: begin
          // open a gap at the write position, top entry first
          if (i_q > size_t'(wp_q)) begin
            state_q <= ST_SHW;
          end else begin
            ws_q    <= ws_q + size_t'(1);
            state_q <= ST_DONE;
          end
        end
        ST_SHW: begin
          valid_q[addr_t'(i_q)] <= 1'b1;
          i_q                   <= i_q - size_t'(1);
          state_q               <= ST_SHR;
        end
        ST_KR: begin
          if ((i_q + size_t'(1)) < ws_q) begin
            state_q <= ST_KW;
          end else begin
            ws_q    <= ws_dec;
            wp_q    <= shr_wp;
            mode_q  <= M_SHRINK;
            state_q <= ST_CAP;
          end
        end
        ST_KW: begin
          valid_q[addr_t'(i_q)] <= 1'b1;
          i_q                   <= i_q + size_t'(1);
          state_q               <= ST_KR;
        end
        ST_DONE: begin
          if (res_load) begin
            res_q.alarm_valid        <= alarm_q;
            res_q.alarm_delay_us     <= delay_q;
            res_q.crossing_period_us <= pi_q;
            res_q.phase_flags        <= flags_q;
            res_q.window_length      <= ws_q;
            res_q.rejected_crossing  <= rej_q;
            state_q                  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

>>> rtl/core/bemf_zero_crossing_detector_top.sv
// Top level of the back-EMF zero-crossing detector: configuration registers,
// sequencer, shared adder and window RAM. Depends on bemfzc_pkg, bemfzc_if,
// bemfzc_ram, bemfzc_alu and bemfzc_ctrl.
//
//   channel  direction  handshake          contents
//   in_i     sink       valid/ready        operation, now_us, phase_a/b/c
//   out_o    source     valid/ready        alarm, delay, period, flags, window, reject
//   cfg      write      cfg_we_i           cfg_idx_i selects, cfg_data_i value
//
// A processed sample takes longer than a marker or a blanked sample, the more
// so the further the three hysteresis tests run; a resize adds entry moves
// through the window RAM. Sums, tests, period filter and delay use the shared
// adder; index steps and the level threshold have their own logic. Reset
// leaves the window RAM contents alone: per-entry valid bits make unwritten
// entries read as zero. A finished result waits in the output register while
// the next transaction is taken; a held result stalls only the next completion.
module bemf_zero_crossing_detector_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  bemfzc_in_if.sink           in_i,
  bemfzc_out_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import bemfzc_pkg::*;

  cfg_t    cfg_q;
  logic    reseed_q;
  item_t   item;
  result_t result;
  word_t   alu_a, alu_b, alu_c, alu_res;
  logic    ram_we;
  addr_t   ram_waddr, ram_raddr;
  entry_t  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis      <= HystReset;
      cfg_q.min_level       <= MinLvlReset;
      cfg_q.guard_time_us   <= GuardReset;
      cfg_q.max_period_us   <= MaxPerReset;
      cfg_q.advance_us      <= AdvReset;
      cfg_q.detect_delay_us <= DetDlyReset;
      reseed_q              <= 1'b0;
    end else begin
      reseed_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HYST:    cfg_q.hysteresis      <= cfg_data_i;
          CFG_MIN_LVL: cfg_q.min_level       <= cfg_data_i[11:0];
          CFG_GUARD:   cfg_q.guard_time_us   <= cfg_data_i;
          CFG_MAX_PER: begin
            cfg_q.max_period_us <= cfg_data_i;
            reseed_q            <= 1'b1;
          end
          CFG_ADVANCE: cfg_q.advance_us      <= cfg_data_i;
          CFG_DET_DLY: cfg_q.detect_delay_us <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign item.operation = in_i.operation;
  assign item.now_us    = in_i.now_us;
  assign item.phase_a   = in_i.phase_a;
  assign item.phase_b   = in_i.phase_b;
  assign item.phase_c   = in_i.phase_c;

  bemfzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (result),
    .cfg_i       (cfg_q),
    .reseed_i    (reseed_q),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_c_o     (alu_c),
    .alu_res_i   (alu_res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bemfzc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .res_o (alu_res)
  );

  bemfzc_ram #(
    .Width (EntryW),
    .Depth (HistDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.alarm_valid        = result.alarm_valid;
  assign out_o.alarm_delay_us     = result.alarm_delay_us;
  assign out_o.crossing_period_us = result.crossing_period_us;
  assign out_o.phase_flags        = result.phase_flags;
  assign out_o.window_length      = result.window_length;
  assign out_o.rejected_crossing  = result.rejected_crossing;

endmodule

>>> test/bemf_zero_crossing_detector_top_test.sv
// Testbench for bemf_zero_crossing_detector_top: a directed table, then simulated motor
// waveforms with noise under several register settings, checked against a local predictor.
// Depends on bemfzc_pkg, bemfzc_if and the detector RTL.
module bemf_zero_crossing_detector_top_test;
  import bemfzc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CfgUnused = 3'd6;
  localparam logic [2:0] CfgSpare  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  bemfzc_in_if in_ch ();
  bemfzc_out_if out_ch ();

  bemf_zero_crossing_detector_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // detector state mirror
  logic [11:0] win_a [HistDepth];
  logic [11:0] win_b [HistDepth];
  logic [11:0] win_c [HistDepth];
  logic [31:0] acc_a, acc_b, acc_c;
  int unsigned wr_pos, win_len;
  logic [2:0] lvl_flags;
  bit blanking;
  logic [31:0] comm_t, zc_t;
  longint period_q;
  int unsigned period_us, hold_off;
  cfg_t regs;

  result_t pending_q[$];
  int errors = 0;
  int n_items = 0, n_alarms = 0, n_rejects = 0, n_results = 0;
  bit stall_free = 1'b0;

  function automatic void reseed_period();
    period_q = longint'(regs.max_period_us / 2) <<< QShift;
    period_us = regs.max_period_us / 2;
  endfunction

  function automatic void mirror_reset();
    for (int i = 0; i < HistDepth; i++) begin
      win_a[i] = '0; win_b[i] = '0; win_c[i] = '0;
    end
    acc_a = '0; acc_b = '0; acc_c = '0;
    wr_pos = 0; win_len = HistDepth; lvl_flags = '0;
    blanking = 1'b0; comm_t = '0; zc_t = '0;
    regs = '{HystReset, MinLvlReset, GuardReset, MaxPerReset, AdvReset, DetDlyReset};
    reseed_period();
    hold_off = regs.max_period_us;
  endfunction

  function automatic bit hyst_flip(int unsigned b, logic [31:0] own, logic [31:0] o1,
                                   logic [31:0] o2);
    longint unsigned mean;
    mean = (longint'(o1) + longint'(o2)) >> 1;
    if (!lvl_flags[b]) begin
      if (longint'(own) >= mean + regs.hysteresis) begin
        lvl_flags[b] = 1'b1; return 1'b1;
      end
    end else if (longint'(own) + regs.hysteresis <= mean) begin
      lvl_flags[b] = 1'b0; return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void resize_window();
    int unsigned need;
    need = period_us / NeedDiv;
    if (need > win_len + 1 && win_len < HistDepth) begin
      acc_a += win_a[wr_pos]; acc_b += win_b[wr_pos]; acc_c += win_c[wr_pos];
      for (int unsigned i = win_len; i > wr_pos; i--) begin
        win_a[i] = win_a[i-1]; win_b[i] = win_b[i-1]; win_c[i] = win_c[i-1];
      end
      win_len++;
    end else if (need + 1 < win_len && need > 1) begin
      for (int unsigned i = wr_pos; i + 1 < win_len; i++) begin
        win_a[i] = win_a[i+1]; win_b[i] = win_b[i+1]; win_c[i] = win_c[i+1];
      end
      win_len--;
      if (wr_pos >= win_len) wr_pos = 0;
      acc_a -= win_a[wr_pos]; acc_b -= win_b[wr_pos]; acc_c -= win_c[wr_pos];
    end
  endfunction

  function automatic result_t predict_crossing(item_t it);
    result_t r;
    bit go, flip;
    logic [31:0] elapsed, p;
    longint unsigned total;
    longint diff, d, dl;
    r = '0;
    if (it.operation) begin
      blanking = 1'b1;
      comm_t = it.now_us;
    end else begin
      go = 1'b1;
      if (blanking) begin
        if (it.now_us - comm_t > regs.guard_time_us) blanking = 1'b0;
        else go = 1'b0;
      end
      if (go) begin
        win_a[wr_pos] = it.phase_a; win_b[wr_pos] = it.phase_b; win_c[wr_pos] = it.phase_c;
        wr_pos = (wr_pos + 1) % win_len;
        acc_a += 32'(it.phase_a) - 32'(win_a[wr_pos]);
        acc_b += 32'(it.phase_b) - 32'(win_b[wr_pos]);
        acc_c += 32'(it.phase_c) - 32'(win_c[wr_pos]);
        total = longint'(acc_a) + longint'(acc_b) + longint'(acc_c);
        elapsed = it.now_us - zc_t;
        if (total / win_len > longint'(regs.min_level) * 3 && elapsed > hold_off) begin
          flip = hyst_flip(0, acc_a, acc_b, acc_c);
          if (!flip) flip = hyst_flip(1, acc_b, acc_a, acc_c);
          if (!flip) flip = hyst_flip(2, acc_c, acc_a, acc_b);
          if (flip && elapsed > MinAcceptUs) begin
            p = (elapsed > regs.max_period_us) ? 32'(regs.max_period_us) : elapsed;
            diff = (longint'(p) <<< QShift) - period_q;
            if (diff >= 0) d = diff >>> FilterShift;
            else d = -((-diff + ((1 << FilterShift) - 1)) >>> FilterShift);
            period_q += d;
            period_us = 32'((period_q >>> QShift) & 64'hFFFF);
            dl = longint'(period_us / 2) - (longint'(regs.detect_delay_us) * HistDepth) / 2
               - longint'(regs.advance_us);
            if (dl < 0) dl = 0;
            if (dl > 16'hFFFF) dl = 16'hFFFF;
            r.alarm_valid = 1'b1;
            r.alarm_delay_us = 16'(dl);
            resize_window();
            blanking = 1'b0;
            zc_t = it.now_us;
            hold_off = period_us * 3 / 4;
          end else if (flip) begin
            zc_t = it.now_us;
            r.rejected_crossing = 1'b1;
          end
        end
      end
    end
    r.crossing_period_us = 16'(period_us);
    r.phase_flags = lvl_flags;
    r.window_length = size_t'(win_len);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        result_t e;
        e = pending_q.pop_front();
        if (out_ch.alarm_valid !== e.alarm_valid) begin
          $error("alarm_valid exp %0d got %0d", e.alarm_valid, out_ch.alarm_valid); errors++;
        end
        if (out_ch.alarm_delay_us !== e.alarm_delay_us) begin
          $error("alarm_delay_us exp %0d got %0d", e.alarm_delay_us, out_ch.alarm_delay_us);
          errors++;
        end
        if (out_ch.crossing_period_us !== e.crossing_period_us) begin
          $error("crossing_period_us exp %0d got %0d", e.crossing_period_us,
                 out_ch.crossing_period_us);
          errors++;
        end
        if (out_ch.phase_flags !== e.phase_flags) begin
          $error("phase_flags exp %0d got %0d", e.phase_flags, out_ch.phase_flags); errors++;
        end
        if (out_ch.window_length !== e.window_length) begin
          $error("window_length exp %0d got %0d", e.window_length, out_ch.window_length);
          errors++;
        end
        if (out_ch.rejected_crossing !== e.rejected_crossing) begin
          $error("rejected_crossing exp %0d got %0d", e.rejected_crossing,
                 out_ch.rejected_crossing);
          errors++;
        end
        if (e.alarm_valid) n_alarms++;
        if (e.rejected_crossing) n_rejects++;
      end
    end
  end

  // result receiver with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = stall_free ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // runs on a negedge; leaves on a negedge after the transaction
  task automatic send_item(item_t it, bit typed, result_t typed_res);
    int gap;
    result_t r;
    gap = stall_free ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.now_us <= it.now_us;
    in_ch.phase_a <= it.phase_a;
    in_ch.phase_b <= it.phase_b;
    in_ch.phase_c <= it.phase_c;
    do @(posedge clk_i); while (!in_ch.ready);
    r = predict_crossing(it);
    pending_q.push_back(typed ? typed_res : r);
    n_items++;
    @(negedge clk_i);
  endtask

  // hold until drained, then let any resize finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2 * HistDepth + 40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HYST:    regs.hysteresis = v;
      CFG_MIN_LVL: regs.min_level = v[11:0];
      CFG_GUARD:   regs.guard_time_us = v;
      CFG_MAX_PER: begin regs.max_period_us = v; reseed_period(); end
      CFG_ADVANCE: regs.advance_us = v;
      CFG_DET_DLY: regs.detect_delay_us = v;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] hy, logic [15:0] ml, logic [15:0] gd,
                           logic [15:0] mp, logic [15:0] ad, logic [15:0] dd);
    write_reg(CFG_HYST, hy);
    write_reg(CFG_MIN_LVL, ml);
    write_reg(CFG_GUARD, gd);
    write_reg(CFG_MAX_PER, mp);
    write_reg(CFG_ADVANCE, ad);
    write_reg(CFG_DET_DLY, dd);
  endtask

  // motor-like waveforms: each phase high for three of six sectors, random markers and items
  logic [31:0] motor_t;
  int unsigned motor_per;

  function automatic item_t motor_item();
    item_t it;
    int unsigned sec, step;
    it = '0;
    if ($urandom_range(0, 9) == 0) begin
      it.operation = $urandom_range(0, 1);
      it.now_us = $urandom;
      it.phase_a = $urandom; it.phase_b = $urandom; it.phase_c = $urandom;
      return it;
    end
    step = motor_per / 6;
    motor_t += $urandom_range(10, step / 3 + 10);
    it.now_us = motor_t;
    sec = (motor_t / step) % 6;
    it.operation = ($urandom_range(0, 99) < 8);
    it.phase_a = (sec < 3) ? 12'($urandom_range(2500, 4095)) : 12'($urandom_range(0, 600));
    it.phase_b = (sec >= 2 && sec < 5) ? 12'($urandom_range(2500, 4095))
                                       : 12'($urandom_range(0, 600));
    it.phase_c = (sec >= 4 || sec == 0) ? 12'($urandom_range(2500, 4095))
                                        : 12'($urandom_range(0, 600));
    return it;
  endfunction

  typedef struct {
    logic        op;
    logic [31:0] t;
    logic [11:0] a, b, c;
    bit          typed;
    result_t     res;
  } row_t;

  initial begin
    row_t rows [$];
    result_t idle_res;
    item_t it;
    int unsigned pers [4];
    mirror_reset();
    in_ch.valid = 1'b0; in_ch.operation = 1'b0; in_ch.now_us = '0;
    in_ch.phase_a = '0; in_ch.phase_b = '0; in_ch.phase_c = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_res = '{1'b0, 16'd0, 16'd5000, 3'd0, size_t'(HistDepth), 1'b0};
    // marker at time zero still blanks; samples inside the guard are dropped
    rows.push_back('{1'b1, 32'd0, 12'd0, 12'd0, 12'd0, 1'b1, idle_res});
    rows.push_back('{1'b0, 32'd10, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, idle_res});
    rows.push_back('{1'b0, 32'd50, 12'hFFF, 12'd0, 12'd0, 1'b1, idle_res});
    rows.push_back('{1'b0, 32'd51, 12'hFFF, 12'd0, 12'd0, 1'b0, idle_res});
    for (int i = 0; i < 8; i++)
      rows.push_back('{1'b0, 32'd100 + i, 12'hFFF, 12'hFFF, 12'd0, 1'b0, idle_res});
    // past the detect window: flips and accepted crossings
    for (int i = 0; i < 4; i++)
      rows.push_back('{1'b0, 32'd12000 + 32'd200 * i, 12'hFFF, 12'd0, 12'd0, 1'b0, idle_res});
    rows.push_back('{1'b0, 32'd22000, 12'd0, 12'hFFF, 12'hFFF, 1'b0, idle_res});
    rows.push_back('{1'b0, 32'd22100, 12'd0, 12'd0, 12'hFFF, 1'b0, idle_res});
    rows.push_back('{1'b1, 32'hFFFF_FFF0, 12'd0, 12'd0, 12'd0, 1'b0, idle_res});
    rows.push_back('{1'b0, 32'h0000_0010, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, idle_res});
    rows.push_back('{1'b0, 32'h0000_0060, 12'hAAA, 12'h555, 12'hFFF, 1'b0, idle_res});
    rows.push_back('{1'b0, 32'hFFFF_FFFF, 12'h555, 12'hAAA, 12'd0, 1'b0, idle_res});
    foreach (rows[i]) begin
      it = '{rows[i].op, rows[i].t, rows[i].a, rows[i].b, rows[i].c};
      send_item(it, rows[i].typed, rows[i].res);
    end

    pers = '{1200, 4000, 20000, 9000};
    motor_t = 32'hFFFF_0000;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: write_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
        2: begin
          write_all(16'hFFFF, 16'd4095, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
          write_reg(CfgUnused, 16'hFFFF);
          write_reg(CfgSpare, 16'h1234);
        end
        3: write_all(16'd200, 16'd50, 16'd100, 16'd30000, 16'd100, 16'd4);
        default: ;
      endcase
      motor_per = pers[ph];
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) stall_free = (k == 50);
        send_item(motor_item(), 1'b0, idle_res);
      end
      stall_free = 1'b0;
    end

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2 * HistDepth + 40) @(negedge clk_i);
    $display("covered %0d items, %0d results, %0d scheduled commutations, %0d early flips",
             n_items, n_results, n_alarms, n_rejects);
    $display("settings: reset values, all-low, all-high and a mid set, with timer wrap");
    if (errors == 0) begin
      $display("bemf_zero_crossing_detector_top_test: clean");
    end else begin
      $display("bemf_zero_crossing_detector_top_test: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("bemf_zero_crossing_detector_top_test: errors");
    $finish;
  end

endmodule
